### hw/rtl/bale_pkg.sv
// Shared constants and types for the bounded array list engine.
// No dependencies; used by bale_cell, bale_row and bounded_array_list_engine.
package bale_pkg;

  localparam int DEPTH       = 128;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CAP_W       = 8;
  localparam int ANS_W       = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

  typedef logic [VALUE_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // what every cell in the row does on the coming edge
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_ROTL
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    cnt_t      pos;      // insert / delete index
    cnt_t      last;     // index of the last live entry
    cnt_t      lo;       // lower bound of the duplicate-check window
    word_t     ins_val;
  } cell_ctl_t;

endpackage

### hw/rtl/bounded_array_list_engine.sv
// Top level of the bounded array list engine: command decode, sequencer
// and result registers around the bale_row cell chain. Uses bale_pkg.
//
//  port group          dir  handshake            contents
//  cfg_we / cfg_data   in   write on cfg_we      capacity_limit
//  start / func..value in   start && !busy       one operation
//  done / status..     out  done, one cycle      status, answer, size_after
//
// Insert, delete, rotate left, size and unused codes finish without going
// busy; a new transaction may start in the next cycle. Find, freq and
// distinct circulate the list once through the cell chain (not when empty).
// Rotate right is count-1 left steps. done rises in the cycle after the
// work. Synchronous reset empties the list and sets the limit to 100.
// The result receiver cannot stall; done marks each result for one cycle only.
module bounded_array_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               start,
  input  logic [3:0]         func,
  input  logic [7:0]         position,
  input  logic [31:0]        value,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [8:0]  answer,
  output logic [7:0]         size_after
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  typedef enum logic [3:0] {
    F_INS_FRONT, F_INS_END, F_INS_POS, F_DEL_FRONT, F_DEL_END, F_DEL_POS,
    F_FIND, F_ROTL, F_ROTR, F_FREQ, F_DISTINCT, F_SIZE
  } func_t;

  typedef enum logic [1:0] {ST_OK, ST_FULL, ST_EMPTY, ST_BADPOS} status_t;

  state_t                         state;
  func_t                          op;
  bale_pkg::cnt_t                 count;
  bale_pkg::cnt_t                 steps;
  bale_pkg::cnt_t                 step;
  logic [bale_pkg::ANS_W-1:0]     acc;
  logic                           found;
  bale_pkg::word_t                key;
  logic [bale_pkg::CAP_W-1:0]     cap;

  bale_pkg::cell_ctl_t            ctl;
  bale_pkg::word_t                first;
  logic                           any_dup;

  logic                           accept;
  logic [15:0]                    cap16, cnt16, pos16, ins16, eff16;
  func_t                          fdec;
  status_t                        imm_status;
  logic [bale_pkg::ANS_W-1:0]     imm_answer;
  bale_pkg::cnt_t                 count_next;
  logic                           go_run;
  bale_pkg::cnt_t                 run_steps;
  logic [bale_pkg::ANS_W-1:0]     acc_init;
  logic [bale_pkg::ANS_W-1:0]     acc_next;
  logic                           found_next;
  logic                           last_step;
  bale_pkg::word_t                in_val;

  assign busy   = (state == S_RUN);
  assign accept = start && !busy;
  assign fdec   = func_t'(func);
  assign in_val = bale_pkg::VALUE_WIDTH'(value);

  assign cap16 = 16'(cap);
  assign cnt16 = 16'(count);
  assign pos16 = 16'(position);
  assign eff16 = (cap16 < 16'(bale_pkg::DEPTH)) ? cap16 : 16'(bale_pkg::DEPTH);
  assign ins16 = (fdec == F_INS_FRONT) ? 16'd0 :
                 (fdec == F_INS_END)   ? cnt16 : pos16;

  assign last_step = (step == steps - 1'b1);

  bale_row u_row (
    .clk     (clk),
    .ctl     (ctl),
    .first   (first),
    .any_dup (any_dup)
  );

  // decode of a new transaction and the row command for this cycle
  always_comb begin
    ctl.cmd     = bale_pkg::CMD_HOLD;
    ctl.pos     = '0;
    ctl.last    = count - 1'b1;
    ctl.lo      = count - step;
    ctl.ins_val = in_val;
    imm_status  = ST_OK;
    imm_answer  = '0;
    count_next  = count;
    go_run      = 1'b0;
    run_steps   = count;
    acc_init    = '0;

    if (busy) begin
      ctl.cmd = bale_pkg::CMD_ROTL;
    end else if (accept) begin
      unique case (fdec) inside
        F_INS_FRONT, F_INS_END, F_INS_POS: begin
          if (ins16 > cnt16) begin
            imm_status = ST_BADPOS;
          end else if (cnt16 >= eff16) begin
            imm_status = ST_FULL;
          end else begin
            ctl.cmd    = bale_pkg::CMD_INS;
            ctl.pos    = bale_pkg::CNT_W'(ins16);
            count_next = count + 1'b1;
          end
        end
        F_DEL_FRONT, F_DEL_END: begin
          if (count == '0) begin
            imm_status = ST_EMPTY;
          end else begin
            // deleting the end needs no shift
            if (fdec == F_DEL_FRONT) begin
              ctl.cmd = bale_pkg::CMD_DEL;
            end
            count_next = count - 1'b1;
          end
        end
        F_DEL_POS: begin
          if (pos16 >= cnt16) begin
            imm_status = ST_BADPOS;
          end else begin
            ctl.cmd    = bale_pkg::CMD_DEL;
            ctl.pos    = bale_pkg::CNT_W'(pos16);
            count_next = count - 1'b1;
          end
        end
        F_ROTL: begin
          if (count == '0) begin
            imm_status = ST_EMPTY;
          end else begin
            ctl.cmd = bale_pkg::CMD_ROTL;
          end
        end
        F_ROTR: begin
          if (count == '0) begin
            imm_status = ST_EMPTY;
          end else if (count != bale_pkg::CNT_W'(1)) begin
            go_run    = 1'b1;
            run_steps = count - 1'b1;
          end
        end
        F_FIND, F_FREQ, F_DISTINCT: begin
          if (fdec == F_FIND) begin
            acc_init   = '1;
            imm_answer = '1;
          end
          go_run = (count != '0);
        end
        F_SIZE: begin
          imm_answer = bale_pkg::ANS_W'(count);
        end
        default: begin
        end
      endcase
    end
  end

  // one circulation step: head of the row is entry number step
  always_comb begin
    acc_next   = acc;
    found_next = found;
    case (op)
      F_FIND: begin
        if (!found && first == key) begin
          acc_next   = bale_pkg::ANS_W'(step);
          found_next = 1'b1;
        end
      end
      F_FREQ: begin
        if (first == key) begin
          acc_next = acc + 1'b1;
        end
      end
      F_DISTINCT: begin
        if (!any_dup) begin
          acc_next = acc + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cap   <= bale_pkg::CAP_RESET;
      done  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (go_run) begin
              state <= S_RUN;
              op    <= fdec;
              steps <= run_steps;
              step  <= '0;
              acc   <= acc_init;
              found <= 1'b0;
              key   <= in_val;
            end else begin
              done       <= 1'b1;
              status     <= imm_status;
              answer     <= imm_answer;
              size_after <= 8'(count_next);
            end
          end
        end
        S_RUN: begin
          step  <= step + 1'b1;
          acc   <= acc_next;
          found <= found_next;
          if (last_step) begin
            state      <= S_IDLE;
            done       <= 1'b1;
            status     <= ST_OK;
            answer     <= acc_next;
            size_after <= 8'(count);
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= bale_pkg::CNT_W'(bale_pkg::DEPTH))
    else $error("entry count beyond store depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + 1'b1 || count == $past(count) - 1'b1))
    else $error("entry count moved by more than one");

  a_run_quiet: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !done)
    else $error("result strobe at start of circulation");
`endif

endmodule

### hw/rtl/bale_cell.sv
// One list slot: holds a word, takes from a neighbour on insert, delete
// and rotate, and flags a match against the head word. Uses bale_pkg.
module bale_cell (
  input  logic                         clk,
  input  logic [bale_pkg::IDX_W-1:0]   idx,
  input  bale_pkg::cell_ctl_t          ctl,
  input  bale_pkg::word_t              left,
  input  bale_pkg::word_t              right,
  input  bale_pkg::word_t              first,
  output bale_pkg::word_t              data,
  output logic                         dup
);

  bale_pkg::cnt_t pos_i;

  assign pos_i = bale_pkg::CNT_W'(idx);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      bale_pkg::CMD_INS: begin
        if (pos_i == ctl.pos) begin
          data <= ctl.ins_val;
        end else if (pos_i > ctl.pos) begin
          data <= left;
        end
      end
      bale_pkg::CMD_DEL: begin
        if (pos_i >= ctl.pos) begin
          data <= right;
        end
      end
      bale_pkg::CMD_ROTL: begin
        if (pos_i < ctl.last) begin
          data <= right;
        end else if (pos_i == ctl.last) begin
          data <= first;
        end
      end
      bale_pkg::CMD_HOLD: begin
      end
    endcase
  end

  // head word seen again within the window of earlier entries
  assign dup = (data == first) && (pos_i >= ctl.lo) && (pos_i <= ctl.last);

endmodule

### hw/rtl/bale_row.sv
// Row of DEPTH bale_cell slots chained left to right, with the head word
// broadcast back and an OR of the match flags. Uses bale_pkg, bale_cell.
module bale_row (
  input  logic                 clk,
  input  bale_pkg::cell_ctl_t  ctl,
  output bale_pkg::word_t      first,
  output logic                 any_dup
);

  bale_pkg::word_t             cell_data [bale_pkg::DEPTH];
  logic [bale_pkg::DEPTH-1:0]  dup_vec;

  assign first   = cell_data[0];
  assign any_dup = |dup_vec;

  for (genvar g = 0; g < bale_pkg::DEPTH; g++) begin : g_cell
    bale_pkg::word_t left_w;
    bale_pkg::word_t right_w;

    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_body
      assign left_w = cell_data[g-1];
    end

    if (g == bale_pkg::DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_data[g+1];
    end

    bale_cell u_cell (
      .clk   (clk),
      .idx   (bale_pkg::IDX_W'(g)),
      .ctl   (ctl),
      .left  (left_w),
      .right (right_w),
      .first (cell_data[0]),
      .data  (cell_data[g]),
      .dup   (dup_vec[g])
    );
  end

endmodule
